FILE: rtl/core/bas_pkg.sv
// Package for the barometric altitude smoother: codes, limits, the job struct
// handed to the arithmetic core, and the constant square-root table builder.
// No dependencies.
`timescale 1ns / 1ps

package bas_pkg;

    // Request function codes
    localparam logic [1:0] FUNC_PRESSURE = 2'd0;
    localparam logic [1:0] FUNC_TEMP     = 2'd1;
    localparam logic [1:0] FUNC_CLEAR    = 2'd2;
    localparam logic [1:0] FUNC_QUERY    = 2'd3;

    // Configuration register indexes
    localparam logic CFG_SEA_LEVEL = 1'b0;
    localparam logic CFG_WEIGHT    = 1'b1;

    localparam int CFG_DATA_W = 23;

    // Register reset values
    localparam logic [22:0] SEA_LEVEL_RST = 23'd4150272;
    localparam logic [15:0] WEIGHT_RST    = 16'd58982;

    // Clamp limits
    localparam logic [23:0] P_MIN = 24'd1064960;
    localparam logic [23:0] P_MAX = 24'd5160960;
    localparam logic signed [15:0] T_MIN = -16'sd4000;
    localparam logic signed [15:0] T_MAX = 16'sd8500;
    localparam logic signed [21:0] ALT_MIN = -22'sd300000;
    localparam logic signed [21:0] ALT_MAX = 22'sd1700000;
    localparam logic [28:0] ALT_MIN_MAG = 29'd300000;
    localparam logic [28:0] ALT_MAX_MAG = 29'd1700000;

    // 0.1902226 in Q24
    localparam logic [21:0] EXP_K = 22'd3191406;
    localparam logic [15:0] KELVIN_OFS = 16'd27315;

    // ceil(2^31 / 13): floor(q * DIV13_RECIP / 2^31) == q / 13 for q below 2^30
    localparam logic [27:0] DIV13_RECIP = 28'd165191050;

    typedef logic [31:0] root_tab_t [24];

    // Work handed to the arithmetic core
    typedef struct packed {
        logic [23:0]        pressure;
        logic [22:0]        sea_level;
        logic signed [15:0] temperature;
        logic [15:0]        weight;
        logic signed [21:0] filt;
        logic               smooth;
    } bas_job_t;

    // Clamp a pressure to the supported range
    function automatic logic [22:0] clamp_p(input logic [23:0] v);
        logic [23:0] c;
        c = v;
        if (v < P_MIN) c = P_MIN;
        if (v > P_MAX) c = P_MAX;
        return c[22:0];
    endfunction

    // Floor integer square root, used only for elaboration constants
    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] res;
        logic [63:0] b;
        logic [63:0] v;
        v   = val;
        res = '0;
        b   = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Entry i holds 2^(2^(i-24)) in Q30
    function automatic root_tab_t build_roots();
        root_tab_t   t;
        logic [63:0] s;
        s = 64'd1 << 31;
        for (int k = 23; k >= 0; k--) begin
            s    = isqrt64(s << 30);
            t[k] = s[31:0];
        end
        return t;
    endfunction

endpackage

FILE: rtl/core/bas_sample_if.sv
// Request channel of the altitude smoother: valid/ready plus sample payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface bas_sample_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [23:0]        pressure_sample;
    logic signed [15:0] temperature_sample;

    modport source (output valid, func, pressure_sample, temperature_sample, input ready);
    modport sink   (input valid, func, pressure_sample, temperature_sample, output ready);
endinterface

FILE: rtl/core/bas_result_if.sv
// Result channel of the altitude smoother: valid/ready plus altitude payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface bas_result_if;
    logic               valid;
    logic               ready;
    logic signed [21:0] altitude_cm;
    logic signed [21:0] smoothed_altitude_cm;
    logic               no_pressure_yet;

    modport source (output valid, altitude_cm, smoothed_altitude_cm, no_pressure_yet,
                    input ready);
    modport sink   (input valid, altitude_cm, smoothed_altitude_cm, no_pressure_yet,
                    output ready);
endinterface

FILE: rtl/core/bas_core.sv
// Iterative arithmetic core: log2 of both pressures, exponent, 2^x, scaling by
// temperature, divide by 13, saturation and smoothing on one shared multiplier.
// Depends on bas_pkg.
`timescale 1ns / 1ps

module bas_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bas_pkg::bas_job_t job,
    output logic              done,
    output logic signed [21:0] alt,
    output logic signed [21:0] filt_new
);
    import bas_pkg::*;

    localparam root_tab_t ROOT_TAB = build_roots();

    localparam logic [3:0] C_IDLE   = 4'd0;
    localparam logic [3:0] C_LOG    = 4'd1;
    localparam logic [3:0] C_EXPK   = 4'd2;
    localparam logic [3:0] C_EXP    = 4'd3;
    localparam logic [3:0] C_TEMP   = 4'd4;
    localparam logic [3:0] C_MAG    = 4'd5;
    localparam logic [3:0] C_DIV    = 4'd6;
    localparam logic [3:0] C_SAT    = 4'd7;
    localparam logic [3:0] C_SMOOTH = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        pass_reg, pass_next;
    logic        done_reg, done_next;
    logic [30:0] z_reg, z_next;
    logic [28:0] r_reg, r_next;
    logic [28:0] l0_reg, l0_next;
    logic        neg_reg, neg_next;
    logic [23:0] f_reg, f_next;
    logic        half_reg, half_next;
    logic [31:0] y_reg, y_next;
    logic        below_reg, below_next;
    logic [30:0] dy_reg, dy_next;
    logic [26:0] tk2k_reg, tk2k_next;
    logic [28:0] q_reg, q_next;
    logic signed [21:0] alt_reg, alt_next;
    logic signed [21:0] filt_reg, filt_next;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    logic [22:0] p_clamp;
    logic [22:0] p0_clamp;
    logic [22:0] norm_src;
    logic [30:0] norm_z;
    logic [28:0] norm_r;
    logic [31:0] zs;
    logic [28:0] r_step;
    logic [51:0] em_sum;
    logic [23:0] em;
    logic [63:0] y_sum;
    logic [31:0] y_eff;
    logic signed [15:0] tc;
    logic [15:0] tk;
    logic [58:0] q_sum;
    logic signed [22:0] fdiff;
    logic signed [40:0] num;

    assign p_clamp  = clamp_p(job.pressure);
    assign p0_clamp = clamp_p({1'b0, job.sea_level});

    // Normalize the pressure selected for the next log pass
    always_comb
    begin
        norm_src = (pass_reg || state_reg == C_IDLE) ? p0_clamp : p_clamp;
        if (state_reg == C_LOG) norm_src = p_clamp;
        if (norm_src[22]) begin
            norm_z = {norm_src[22:0], 8'b0};
            norm_r = {5'd22, 24'b0};
        end else if (norm_src[21]) begin
            norm_z = {norm_src[21:0], 9'b0};
            norm_r = {5'd21, 24'b0};
        end else begin
            norm_z = {norm_src[20:0], 10'b0};
            norm_r = {5'd20, 24'b0};
        end
    end

    // Clamped temperature in kelvin times 100
    always_comb
    begin
        tc = job.temperature;
        if (tc < T_MIN) tc = T_MIN;
        if (tc > T_MAX) tc = T_MAX;
        tk = 16'(tc) + KELVIN_OFS;
    end

    // Shared multiplier operand selection
    always_comb
    begin
        case (state_reg)
            C_LOG:
            begin
                mul_a = {2'b0, z_reg};
                mul_b = {2'b0, z_reg};
            end
            C_EXPK:
            begin
                mul_a = {4'b0, l0_reg};
                mul_b = {11'b0, EXP_K};
            end
            C_EXP:
            begin
                mul_a = {1'b0, y_reg};
                mul_b = {1'b0, ROOT_TAB[cnt_reg]};
            end
            C_MAG:
            begin
                mul_a = {2'b0, dy_reg};
                mul_b = {6'b0, tk2k_reg};
            end
            C_DIV:
            begin
                mul_a = {4'b0, q_reg};
                mul_b = {5'b0, DIV13_RECIP};
            end
            C_SMOOTH:
            begin
                mul_a = {{10{fdiff[22]}}, fdiff};
                mul_b = {17'b0, job.weight};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign zs     = mul_p[61:30];
    assign r_step = r_reg | (29'd1 << cnt_reg);
    assign em_sum = mul_p[51:0] + (52'd1 << 23);
    assign em     = (|em_sum[51:48]) ? 24'hFFFFFF : em_sum[47:24];
    assign y_sum  = mul_p[63:0] + (64'd1 << 29);
    assign y_eff  = half_reg ? (y_reg >> 1) : y_reg;
    assign q_sum  = mul_p[58:0] + (59'd13 << 29);
    assign fdiff  = {job.filt[21], job.filt} - {alt_reg[21], alt_reg};
    assign num    = {{3{alt_reg[21]}}, alt_reg, 16'b0} + mul_p[40:0] + 41'sd32768;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pass_next  = pass_reg;
        done_next  = 1'b0;
        z_next     = z_reg;
        r_next     = r_reg;
        l0_next    = l0_reg;
        neg_next   = neg_reg;
        f_next     = f_reg;
        half_next  = half_reg;
        y_next     = y_reg;
        below_next = below_reg;
        dy_next    = dy_reg;
        tk2k_next  = tk2k_reg;
        q_next     = q_reg;
        alt_next   = alt_reg;
        filt_next  = filt_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (start) begin
                    z_next     = norm_z;
                    r_next     = norm_r;
                    cnt_next   = 5'd23;
                    pass_next  = 1'b0;
                    state_next = C_LOG;
                end
            end
            C_LOG:
            begin
                // one squaring step of the log2 bit recurrence
                if (zs[31]) begin
                    z_next = zs[31:1];
                    r_next = r_step;
                end else begin
                    z_next = zs[30:0];
                end
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    if (!pass_reg) begin
                        l0_next   = zs[31] ? r_step : r_reg;
                        z_next    = norm_z;
                        r_next    = norm_r;
                        cnt_next  = 5'd23;
                        pass_next = 1'b1;
                    end else begin
                        r_next = zs[31] ? r_step : r_reg;
                        if (l0_reg < r_next) begin
                            neg_next = 1'b1;
                            l0_next  = r_next - l0_reg;
                        end else begin
                            neg_next = 1'b0;
                            l0_next  = l0_reg - r_next;
                        end
                        state_next = C_EXPK;
                    end
                end
            end
            C_EXPK:
            begin
                half_next  = neg_reg && (em != '0);
                f_next     = (neg_reg && (em != '0)) ? (~em + 24'd1) : em;
                y_next     = 32'd1 << 30;
                cnt_next   = 5'd23;
                state_next = C_EXP;
            end
            C_EXP:
            begin
                if (f_reg[cnt_reg]) y_next = y_sum[61:30];
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) state_next = C_TEMP;
            end
            C_TEMP:
            begin
                if (y_eff < (32'd1 << 30)) begin
                    below_next = 1'b1;
                    dy_next    = 31'((32'd1 << 30) - y_eff);
                end else begin
                    below_next = 1'b0;
                    dy_next    = 31'(y_eff - (32'd1 << 30));
                end
                tk2k_next  = ({11'b0, tk} << 11) - ({11'b0, tk} << 5) - ({11'b0, tk} << 4);
                state_next = C_MAG;
            end
            C_MAG:
            begin
                q_next     = q_sum[58:30];
                state_next = C_DIV;
            end
            C_DIV:
            begin
                // divide by 13 as a multiply by the scaled reciprocal
                q_next     = mul_p[59:31];
                state_next = C_SAT;
            end
            C_SAT:
            begin
                if (below_reg) begin
                    if (q_reg > ALT_MIN_MAG) alt_next = ALT_MIN;
                    else alt_next = -$signed({1'b0, q_reg[20:0]});
                end else begin
                    if (q_reg > ALT_MAX_MAG) alt_next = ALT_MAX;
                    else alt_next = $signed({1'b0, q_reg[20:0]});
                end
                if (job.smooth) begin
                    state_next = C_SMOOTH;
                end else begin
                    filt_next  = job.filt;
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end
            end
            C_SMOOTH:
            begin
                filt_next  = num[37:16];
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
            pass_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pass_reg  <= pass_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg     <= z_next;
        r_reg     <= r_next;
        l0_reg    <= l0_next;
        neg_reg   <= neg_next;
        f_reg     <= f_next;
        half_reg  <= half_next;
        y_reg     <= y_next;
        below_reg <= below_next;
        dy_reg    <= dy_next;
        tk2k_reg  <= tk2k_next;
        q_reg     <= q_next;
        alt_reg   <= alt_next;
        filt_reg  <= filt_next;
    end

    assign done     = done_reg;
    assign alt      = alt_reg;
    assign filt_new = filt_reg;

    // Bit loops stay inside the root table
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_LOG || state_reg == C_EXP) |-> cnt_reg <= 5'd23)
        else $error("loop counter out of range");

    // Done is only raised as the core returns to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == C_IDLE)
        else $error("done raised while core busy");

    // Saturated altitude stays inside its limits
    a_alt_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (alt_reg >= ALT_MIN && alt_reg <= ALT_MAX))
        else $error("altitude outside saturation limits");

endmodule

FILE: rtl/core/barometric_altitude_smoother.sv
// Barometric altitude smoother: request and result channels, configuration
// registers, sample stores, filter state and result register.
// Depends on bas_pkg, bas_sample_if, bas_result_if and bas_core.
//
// Usage: each request on 'sample' carries func (pressure sample, temperature
// sample, clear, or query) and the two raw sample fields. Every request gives
// exactly one result on 'result': altitude_cm, smoothed_altitude_cm and
// no_pressure_yet. Configuration writes (cfg_we, cfg_index, cfg_data) set the
// sea level pressure and the smoothing weight and are to be made while idle;
// the block itself does not enforce this. With a pressure stored, a request
// runs through the two bit-serial log2 passes (sea level, then sample), the
// 24-step 2^x product loop and one state each for the exponent, kelvin
// scaling, product, reciprocal divide by 13, saturation and smoothing (a
// query skips smoothing), all on one shared multiplier, then the hand-off
// into the result register. With no pressure stored (or on clear) the result
// is loaded into the result register without starting the core.
// One request is in flight at a time; sample.ready is low until the result
// register is loaded and rises again with that load.
// A stalled receiver holds the result in the output register while the next
// request is worked on; that request's result then waits, with sample.ready
// low, until the output register is freed.
// Reset clears the stores and the filter and loads the register defaults.
`timescale 1ns / 1ps

module barometric_altitude_smoother #(
    parameter logic [22:0] SEA_LEVEL_DEFAULT = bas_pkg::SEA_LEVEL_RST,
    parameter logic [15:0] WEIGHT_DEFAULT    = bas_pkg::WEIGHT_RST
) (
    input  logic                            clk,
    input  logic                            rst_n,
    bas_sample_if.sink                      sample,
    bas_result_if.source                    result,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [bas_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bas_pkg::*;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_BUSY = 2'd1;
    localparam logic [1:0] T_DONE = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [22:0] sea_level_reg;
    logic [15:0] weight_reg;
    logic [23:0] pres_reg, pres_next;
    logic signed [15:0] temperature_reg, temperature_next;
    logic signed [21:0] filt_reg, filt_next;
    logic        smooth_reg, smooth_next;
    logic        start_reg, start_next;
    logic signed [21:0] res_alt_reg, res_alt_next;
    logic signed [21:0] res_filt_reg, res_filt_next;
    logic        res_none_reg, res_none_next;
    logic        ov_reg, ov_next;
    logic signed [21:0] out_alt_reg, out_filt_reg;
    logic        out_none_reg;
    logic        load_out;

    bas_job_t    job;
    logic        core_done;
    logic signed [21:0] core_alt, core_filt;

    assign sample.ready = (state_reg == T_IDLE);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sea_level_reg <= SEA_LEVEL_DEFAULT;
            weight_reg    <= WEIGHT_DEFAULT;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SEA_LEVEL: sea_level_reg <= cfg_data;
                CFG_WEIGHT:    weight_reg    <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    assign job = '{pressure:    pres_reg,
                   sea_level:   sea_level_reg,
                   temperature: temperature_reg,
                   weight:      weight_reg,
                   filt:        filt_reg,
                   smooth:      smooth_reg};

    bas_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .job      (job),
        .done     (core_done),
        .alt      (core_alt),
        .filt_new (core_filt)
    );

    assign load_out = (state_reg == T_DONE) && (!ov_reg || result.ready);

    // Request sequencing and store updates
    always_comb
    begin
        state_next       = state_reg;
        pres_next        = pres_reg;
        temperature_next = temperature_reg;
        filt_next        = filt_reg;
        smooth_next      = smooth_reg;
        start_next       = 1'b0;
        res_alt_next     = res_alt_reg;
        res_filt_next    = res_filt_reg;
        res_none_next    = res_none_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (sample.valid) begin
                    case (sample.func)
                        FUNC_PRESSURE: pres_next = sample.pressure_sample;
                        FUNC_TEMP:     temperature_next = sample.temperature_sample;
                        FUNC_CLEAR:
                        begin
                            pres_next        = '0;
                            temperature_next = '0;
                            filt_next        = '0;
                        end
                        default:       ;
                    endcase
                    smooth_next = (sample.func == FUNC_PRESSURE) ||
                                  (sample.func == FUNC_TEMP);
                    if (pres_next == '0) begin
                        res_alt_next  = '0;
                        res_filt_next = filt_next;
                        res_none_next = 1'b1;
                        state_next    = T_DONE;
                    end else begin
                        start_next = 1'b1;
                        state_next = T_BUSY;
                    end
                end
            end
            T_BUSY:
            begin
                if (core_done) begin
                    res_alt_next  = core_alt;
                    res_filt_next = core_filt;
                    res_none_next = 1'b0;
                    filt_next     = core_filt;
                    state_next    = T_DONE;
                end
            end
            T_DONE:
            begin
                if (load_out) state_next = T_IDLE;
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        ov_next = ov_reg;
        if (load_out) ov_next = 1'b1;
        else if (result.ready) ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= T_IDLE;
            pres_reg        <= '0;
            temperature_reg <= '0;
            filt_reg        <= '0;
            start_reg       <= 1'b0;
            ov_reg          <= 1'b0;
        end else begin
            state_reg       <= state_next;
            pres_reg        <= pres_next;
            temperature_reg <= temperature_next;
            filt_reg        <= filt_next;
            start_reg       <= start_next;
            ov_reg          <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smooth_reg   <= smooth_next;
        res_alt_reg  <= res_alt_next;
        res_filt_reg <= res_filt_next;
        res_none_reg <= res_none_next;
        if (load_out) begin
            out_alt_reg  <= res_alt_reg;
            out_filt_reg <= res_filt_reg;
            out_none_reg <= res_none_reg;
        end
    end

    assign result.valid                = ov_reg;
    assign result.altitude_cm          = out_alt_reg;
    assign result.smoothed_altitude_cm = out_filt_reg;
    assign result.no_pressure_yet      = out_none_reg;

    // One request at a time: busy right after a request is taken
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> !sample.ready)
        else $error("request accepted while another is in flight");

    // Core starts and finishes only while a request is being worked on
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> state_reg == T_BUSY)
        else $error("core started outside busy state");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        core_done |-> state_reg == T_BUSY)
        else $error("core finished outside busy state");

    // Without a pressure the reported altitude is zero
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.no_pressure_yet |-> result.altitude_cm == '0)
        else $error("altitude nonzero with no pressure stored");

endmodule
